// File: rtl/pppl_pkg.sv
package pppl_pkg;

  // Default geometry and fixed-point parameters
  localparam int DEF_CANVAS_COLUMNS = 32;
  localparam int DEF_CANVAS_ROWS    = 32;
  localparam int DEF_FRACTION_BITS  = 8;

  // Fixed field widths
  localparam int COORD_W    = 16;
  localparam int PLOT_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = 16;  // |coordinate| up to 32768
  localparam int GAIN_W     = 32;  // 2*m*D
  localparam int DEN_W      = 33;  // 2*m*D + (1-m)(D-z)
  localparam int STEP_N_W   = 6;   // line step count, at most 63

  // Register reset values
  localparam logic [14:0] RST_DEPTH_RANGE = 15'd4096;
  localparam logic [15:0] RST_MIN_SCALE   = 16'd32768;
  localparam logic [14:0] RST_ASPECT      = 15'd8192;
  localparam logic        RST_LINE_MODE   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEPTH_RANGE = 2'd0,
    CFG_MIN_SCALE   = 2'd1,
    CFG_ASPECT      = 2'd2,
    CFG_LINE_MODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_PDIV,
    ST_PWAIT,
    ST_SCALE,
    ST_POST,
    ST_LPREP,
    ST_LCHK,
    ST_LWAIT,
    ST_EMIT,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul1;
    logic mul2;
    logic div_start;
    logic div_line;
    logic scale;
    logic post;
    logic line_prep;
    logic emit;
    logic emit_proj;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic line_mode;
    logic start_line;
    logic div_done;
    logic n_zero;
    logic last_step;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/perspective_point_line_plotter_core.sv
// Channel  | Handshake                    | Payload
// input    | in_valid_i / in_stall_o      | point_x_i, point_y_i, point_z_i, first_point_i
// output   | out_valid_o / out_stall_i    | plot_x_o, plot_y_o, on_canvas_o, last_of_run_o
// config   | cfg_we_i                     | cfg_index_i, cfg_data_i
//
// One item at a time. Projection passes the input capture, the MUL1 and MUL2 products, the
// bit-serial perspective divider, the aspect stretch and the rounding stage. A line run
// adds the step-increment division, then n + 1 results, one per cycle while the output
// is not stalled, and a finish state.
// Reset is asynchronous, active low, and clears control state, the configuration registers and the valid flags.
// Output stalls hold the result register and pause the run; a finished result may wait
// while the next item is accepted.
module perspective_point_line_plotter_core import pppl_pkg::*; #(
  parameter int CANVAS_COLUMNS = DEF_CANVAS_COLUMNS,
  parameter int CANVAS_ROWS    = DEF_CANVAS_ROWS,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic                      first_point_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [PLOT_W-1:0]  plot_x_o,
  output logic signed [PLOT_W-1:0]  plot_y_o,
  output logic                      on_canvas_o,
  output logic                      last_of_run_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  pppl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pppl_datapath #(
    .CANVAS_COLUMNS (CANVAS_COLUMNS),
    .CANVAS_ROWS    (CANVAS_ROWS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .first_point_i (first_point_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .plot_x_o      (plot_x_o),
    .plot_y_o      (plot_y_o),
    .on_canvas_o   (on_canvas_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// File: rtl/pppl_div.sv
module pppl_div import pppl_pkg::*; #(
  parameter int NUM_W = 56,
  parameter int DIV_W = 33,
  parameter int QUO_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [DIV_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DIV_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DIV_W:0]   trial;
  logic             ge;

  // One quotient bit per cycle, restoring; quotient is known to fit QUO_W bits
  assign trial = {rem_q, quo_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = DIV_W'(num_i[NUM_W-1:QUO_W]);
      quo_d  = num_i[QUO_W-1:0];
      cnt_d  = CNT_W'(QUO_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(trial - {1'b0, den_q}) : DIV_W'(trial);
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/pppl_datapath.sv
module pppl_datapath import pppl_pkg::*; #(
  parameter int CANVAS_COLUMNS = DEF_CANVAS_COLUMNS,
  parameter int CANVAS_ROWS    = DEF_CANVAS_ROWS,
  parameter int FRACTION_BITS  = DEF_FRACTION_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic signed [COORD_W-1:0] point_x_i,
  input  logic signed [COORD_W-1:0] point_y_i,
  input  logic signed [COORD_W-1:0] point_z_i,
  input  logic                   first_point_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic signed [PLOT_W-1:0] plot_x_o,
  output logic signed [PLOT_W-1:0] plot_y_o,
  output logic                   on_canvas_o,
  output logic                   last_of_run_o
);

  localparam int FB  = FRACTION_BITS;
  localparam int QW  = MAG_W + FB;           // projection quotient
  localparam int NW  = MAG_W + GAIN_W + FB;  // projection numerator
  localparam int PW  = FB + 7;               // projected coordinate, signed
  localparam int AW  = FB + 6;               // |delta| along a line
  localparam int PRW = QW + 16;              // stretched product plus rounding
  localparam int RW  = PRW - 20;
  localparam int SW  = RW + 2;
  localparam logic signed [SW-1:0] WIN_LO = SW'(-16 * (1 << FB));
  localparam logic signed [SW-1:0] WIN_HI = SW'(47 * (1 << FB));
  localparam logic signed [SW-1:0] CTR_X  = SW'(((CANVAS_COLUMNS - 1) / 2) * (1 << FB));
  localparam logic signed [SW-1:0] CTR_Y  = SW'(((CANVAS_ROWS - 1) / 2) * (1 << FB));
  localparam logic signed [PW-1:0] LIM_X  = PW'(CANVAS_COLUMNS * (1 << FB));
  localparam logic signed [PW-1:0] LIM_Y  = PW'(CANVAS_ROWS * (1 << FB));
  localparam logic [PRW-1:0]       HALF   = PRW'(1 << 19);
  localparam logic [AW:0]          CEIL_ADD = (AW+1)'((1 << FB) - 1);

  // Configuration registers
  logic [14:0] depth_range_q;
  logic [15:0] min_scale_q;
  logic [14:0] aspect_q;
  logic        line_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_range_q <= RST_DEPTH_RANGE;
      min_scale_q   <= RST_MIN_SCALE;
      aspect_q      <= RST_ASPECT;
      line_mode_q   <= RST_LINE_MODE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEPTH_RANGE: depth_range_q <= cfg_data_i[14:0];
        CFG_MIN_SCALE:   min_scale_q   <= cfg_data_i;
        CFG_ASPECT:      aspect_q      <= cfg_data_i[14:0];
        CFG_LINE_MODE:   line_mode_q   <= cfg_data_i[0];
        default:         ;
      endcase
    end
  end

  // Input capture
  logic signed [COORD_W-1:0] x_q, y_q, z_q;
  logic                      first_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q     <= point_x_i;
      y_q     <= point_y_i;
      z_q     <= point_z_i;
      first_q <= first_point_i;
    end
  end

  // Stage 1: clamp depth, gain and depth term products
  logic [14:0]        d_eff;
  logic [15:0]        m_eff;
  logic signed [16:0] d_s, z_s, zc;
  logic [15:0]        dz, cm;
  logic [30:0]        md;
  logic [31:0]        tm;
  logic [GAIN_W-1:0]  gain_q;
  logic [31:0]        term_q;
  logic [MAG_W-1:0]   magx_q, magy_q;
  logic               negx_q, negy_q;

  assign d_eff = (depth_range_q == '0) ? 15'd1 : depth_range_q;
  assign m_eff = (min_scale_q == '0) ? 16'd1 : min_scale_q;
  assign d_s   = $signed({2'b00, d_eff});
  assign z_s   = $signed({z_q[COORD_W-1], z_q});

  always_comb begin
    if (z_s > d_s) begin
      zc = d_s;
    end else if (z_s < -d_s) begin
      zc = -d_s;
    end else begin
      zc = z_s;
    end
  end

  assign dz = 16'(d_s - zc);
  assign cm = 16'(17'h10000 - {1'b0, m_eff});
  assign md = m_eff * d_eff;
  assign tm = cm * dz;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      gain_q <= {md, 1'b0};
      term_q <= tm;
      magx_q <= x_q[COORD_W-1] ? MAG_W'(-x_q) : MAG_W'(x_q);
      magy_q <= y_q[COORD_W-1] ? MAG_W'(-y_q) : MAG_W'(y_q);
      negx_q <= x_q[COORD_W-1];
      negy_q <= ~y_q[COORD_W-1];
    end
  end

  // Stage 2: denominator and numerators
  logic [DEN_W-1:0]         den_q;
  logic [MAG_W+GAIN_W-1:0]  nx_mul, ny_mul;
  logic [NW-1:0]            numx_q, numy_q;

  assign nx_mul = magx_q * gain_q;
  assign ny_mul = magy_q * gain_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2) begin
      den_q  <= DEN_W'(gain_q) + DEN_W'(term_q);
      numx_q <= {nx_mul, {FB{1'b0}}};
      numy_q <= {ny_mul, {FB{1'b0}}};
    end
  end

  // Shared dividers: perspective quotient, then per-step line increment
  logic [AW-1:0]       adx_q, ady_q;
  logic [STEP_N_W-1:0] n_q;
  logic [NW-1:0]       dnum_x, dnum_y;
  logic [DEN_W-1:0]    dden;
  logic [QW-1:0]       quo_x, quo_y;
  logic [DEN_W-1:0]    rem_x, rem_y;
  logic                done_x, done_y;

  assign dnum_x = cmd_i.div_line ? NW'(adx_q) : numx_q;
  assign dnum_y = cmd_i.div_line ? NW'(ady_q) : numy_q;
  assign dden   = cmd_i.div_line ? DEN_W'(n_q) : den_q;

  pppl_div #(.NUM_W(NW), .DIV_W(DEN_W), .QUO_W(QW)) u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (dnum_x),
    .den_i   (dden),
    .done_o  (done_x),
    .quo_o   (quo_x),
    .rem_o   (rem_x)
  );

  pppl_div #(.NUM_W(NW), .DIV_W(DEN_W), .QUO_W(QW)) u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (dnum_y),
    .den_i   (dden),
    .done_o  (done_y),
    .quo_o   (quo_y),
    .rem_o   (rem_y)
  );

  // Stage 3: aspect stretch
  logic [PRW-2:0] prodx_q, prody_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      prodx_q <= quo_x * aspect_q;
      prody_q <= {3'b000, quo_y, 12'd0};
    end
  end

  // Stage 4: round, sign, center, saturate
  function automatic logic signed [PW-1:0] fin_coord(input logic [PRW-2:0] prod,
                                                     input logic neg,
                                                     input logic signed [SW-1:0] ctr);
    logic [PRW-1:0]     sum;
    logic [RW-1:0]      r;
    logic signed [SW-1:0] rs, p;
    sum = {1'b0, prod} + HALF;
    r   = sum[PRW-1:20];
    rs  = neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
    p   = rs + ctr;
    if (p < WIN_LO) begin
      p = WIN_LO;
    end else if (p > WIN_HI) begin
      p = WIN_HI;
    end
    return PW'(p);
  endfunction

  logic signed [PW-1:0] proj_x_q, proj_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.post) begin
      proj_x_q <= fin_coord(prodx_q, negx_q, CTR_X);
      proj_y_q <= fin_coord(prody_q, negy_q, CTR_Y);
    end
  end

  // Previous point
  logic signed [PW-1:0] prev_x_q, prev_y_q;
  logic                 prev_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      prev_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      prev_x_q     <= proj_x_q;
      prev_y_q     <= proj_y_q;
      prev_valid_q <= 1'b1;
    end
  end

  // Line setup: deltas and step count ceil(max(|dx|,|dy|))
  logic signed [PW:0] dx, dy;
  logic [AW-1:0]      adx, ady, amx;
  logic [AW:0]        nsum;
  logic               sdx_q, sdy_q;

  assign dx   = $signed({proj_x_q[PW-1], proj_x_q}) - $signed({prev_x_q[PW-1], prev_x_q});
  assign dy   = $signed({proj_y_q[PW-1], proj_y_q}) - $signed({prev_y_q[PW-1], prev_y_q});
  assign adx  = dx[PW] ? AW'(-dx) : AW'(dx);
  assign ady  = dy[PW] ? AW'(-dy) : AW'(dy);
  assign amx  = (adx > ady) ? adx : ady;
  assign nsum = {1'b0, amx} + CEIL_ADD;

  // Step accumulators: offset = trunc(k*|d|/n) via quotient and remainder
  logic [AW-1:0]       offx_q, offy_q;
  logic [STEP_N_W-1:0] remx_q, remy_q, k_q;
  logic [STEP_N_W:0]   tx, ty;
  logic                cx, cy;

  assign tx = {1'b0, remx_q} + {1'b0, rem_x[STEP_N_W-1:0]};
  assign ty = {1'b0, remy_q} + {1'b0, rem_y[STEP_N_W-1:0]};
  assign cx = tx >= {1'b0, n_q};
  assign cy = ty >= {1'b0, n_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.line_prep) begin
      adx_q  <= adx;
      ady_q  <= ady;
      sdx_q  <= dx[PW];
      sdy_q  <= dy[PW];
      n_q    <= nsum[FB+STEP_N_W-1:FB];
      offx_q <= '0;
      offy_q <= '0;
      remx_q <= '0;
      remy_q <= '0;
      k_q    <= '0;
    end else if (cmd_i.emit && !cmd_i.emit_proj) begin
      offx_q <= offx_q + quo_x[AW-1:0] + AW'(cx);
      offy_q <= offy_q + quo_y[AW-1:0] + AW'(cy);
      remx_q <= cx ? STEP_N_W'(tx - {1'b0, n_q}) : STEP_N_W'(tx);
      remy_q <= cy ? STEP_N_W'(ty - {1'b0, n_q}) : STEP_N_W'(ty);
      k_q    <= k_q + 1'b1;
    end
  end

  // Result selection and output register
  logic signed [PW-1:0] lx, ly, ex, ey;
  logic                 out_valid_q, out_free, last_step;

  assign lx = prev_x_q + (sdx_q ? -$signed(PW'(offx_q)) : $signed(PW'(offx_q)));
  assign ly = prev_y_q + (sdy_q ? -$signed(PW'(offy_q)) : $signed(PW'(offy_q)));
  assign ex = cmd_i.emit_proj ? proj_x_q : lx;
  assign ey = cmd_i.emit_proj ? proj_y_q : ly;
  assign last_step = (k_q == n_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      plot_x_o      <= ex[FB+PLOT_W-1:FB];
      plot_y_o      <= ey[FB+PLOT_W-1:FB];
      on_canvas_o   <= !ex[PW-1] && (ex < LIM_X) && !ey[PW-1] && (ey < LIM_Y);
      last_of_run_o <= cmd_i.emit_proj || last_step;
    end
  end

  assign out_valid_o = out_valid_q;

  // Status back to the controller
  assign sts_o.line_mode  = line_mode_q;
  assign sts_o.start_line = !first_q && prev_valid_q;
  assign sts_o.div_done   = done_x && done_y;
  assign sts_o.n_zero     = (n_q == '0);
  assign sts_o.last_step  = last_step;
  assign sts_o.out_free   = out_free;

endmodule

// File: rtl/pppl_ctrl.sv
module pppl_ctrl import pppl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_PDIV;
      end
      ST_PDIV: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_PWAIT;
      end
      ST_PWAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_POST;
      end
      ST_POST: begin
        cmd_o.post = 1'b1;
        priority if (!sts_i.line_mode) begin
          state_d = ST_EMIT;
        end else if (sts_i.start_line) begin
          state_d = ST_LPREP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_LPREP: begin
        cmd_o.line_prep = 1'b1;
        state_d         = ST_LCHK;
      end
      ST_LCHK: begin
        if (sts_i.n_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_line  = 1'b1;
          state_d         = ST_LWAIT;
        end
      end
      ST_LWAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit_proj = !sts_i.line_mode;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.line_mode || sts_i.last_step) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pppl_checker.sv
module pppl_checker import pppl_pkg::*; #(
  parameter int CANVAS_COLUMNS = DEF_CANVAS_COLUMNS,
  parameter int CANVAS_ROWS    = DEF_CANVAS_ROWS
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [PLOT_W-1:0] plot_x_o,
  input logic signed [PLOT_W-1:0] plot_y_o,
  input logic                     on_canvas_o,
  input logic                     last_of_run_o
);

  localparam logic signed [PLOT_W-1:0] LO   = PLOT_W'(-16);
  localparam logic signed [PLOT_W-1:0] HI   = PLOT_W'(47);
  localparam logic signed [PLOT_W-1:0] MAXC = PLOT_W'(CANVAS_COLUMNS - 1);
  localparam logic signed [PLOT_W-1:0] MAXR = PLOT_W'(CANVAS_ROWS - 1);

  // One item in flight: an accepted item closes the input next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(plot_x_o) && $stable(plot_y_o)
      && $stable(last_of_run_o))
    else $error("stalled result changed");

  // Results stay within the saturation window
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> plot_x_o >= LO && plot_x_o <= HI && plot_y_o >= LO && plot_y_o <= HI)
    else $error("result outside window");

  // On-canvas flag agrees with the coordinates
  a_canvas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> on_canvas_o == (plot_x_o >= 0 && plot_x_o <= MAXC
      && plot_y_o >= 0 && plot_y_o <= MAXR))
    else $error("on-canvas flag mismatch");

endmodule

bind perspective_point_line_plotter_core pppl_checker #(
  .CANVAS_COLUMNS (CANVAS_COLUMNS),
  .CANVAS_ROWS    (CANVAS_ROWS)
) u_pppl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .plot_x_o      (plot_x_o),
  .plot_y_o      (plot_y_o),
  .on_canvas_o   (on_canvas_o),
  .last_of_run_o (last_of_run_o)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pppl_pkg::*;

  localparam int COLS       = 32;
  localparam int ROWS       = 32;
  localparam int FRAC       = 8;
  localparam int UNIT       = 1 << FRAC;
  localparam int WIN_LO     = -16 * UNIT;
  localparam int WIN_HI     = 47 * UNIT;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               first;
  } point_t;

  typedef struct {
    logic signed [6:0] px;
    logic signed [6:0] py;
    logic              on;
    logic              last;
  } plot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Block ports
  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic signed [15:0]  pt_x = '0, pt_y = '0, pt_z = '0;
  logic                pt_first = 1'b0;
  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic signed [6:0]   plot_x_o, plot_y_o;
  logic                on_canvas_o, last_of_run_o;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state and register copies
  int unsigned depth_reg  = RST_DEPTH_RANGE;
  int unsigned scale_reg  = RST_MIN_SCALE;
  int unsigned aspect_reg = RST_ASPECT;
  bit          lines_on   = RST_LINE_MODE;
  int          prev_x = 0, prev_y = 0;
  bit          prev_ok = 1'b0;

  point_t pending_points[$];
  plot_t  expected_plots[$];
  point_t cur;
  int     gap_left = 0;
  bit     no_idle = 1'b0;
  int     mismatches = 0;
  int     points_in = 0, plots_out = 0;
  int     cycles = 0;

  perspective_point_line_plotter_core i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o,
    .point_x_i(pt_x), .point_y_i(pt_y), .point_z_i(pt_z), .first_point_i(pt_first),
    .out_valid_o, .out_stall_i(out_stall),
    .plot_x_o, .plot_y_o, .on_canvas_o, .last_of_run_o,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always #5 clk_i = ~clk_i;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_idle || r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Perspective divide, stretch, rounding, centering and window clamp
  function automatic int perspective(int v, bit flip, longint unsigned gain,
                                     longint unsigned den, int unsigned stretch, int ctr);
    longint unsigned mag, q, r;
    longint p;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag * gain) << FRAC) / den;
    r = (q * stretch + (64'd1 << 19)) >> 20;
    p = ((v < 0) != flip) ? -longint'(r) : longint'(r);
    p += ctr * UNIT;
    if (p < WIN_LO) p = WIN_LO;
    if (p > WIN_HI) p = WIN_HI;
    return int'(p);
  endfunction

  function automatic int step_offset(int d, int k, int n);
    int prod, mag;
    prod = d * k;
    mag = ((prod < 0) ? -prod : prod) / n;
    return (prod < 0) ? -mag : mag;
  endfunction

  function automatic void push_plot(int fx, int fy, bit last);
    plot_t e;
    int cx, cy;
    cx = ((fx - WIN_LO) >>> FRAC) - 16;
    cy = ((fy - WIN_LO) >>> FRAC) - 16;
    e.px = cx[6:0];
    e.py = cy[6:0];
    e.on = fx >= 0 && fx < COLS * UNIT && fy >= 0 && fy < ROWS * UNIT;
    e.last = last;
    expected_plots.push_back(e);
  endfunction

  // Expected plots for one accepted point
  function automatic void predict_plots(point_t p);
    int zc, d, qx, qy, dx, dy, ax, ay, mx, n;
    longint unsigned m, gain, den;
    d = (depth_reg != 0) ? int'(depth_reg) : 1;
    m = (scale_reg != 0) ? scale_reg : 1;
    zc = p.z;
    if (zc > d) zc = d;
    if (zc < -d) zc = -d;
    gain = 2 * m * longint'(d);
    den = gain + (65536 - m) * longint'(d - zc);
    qx = perspective(p.x, 1'b0, gain, den, aspect_reg, (COLS - 1) / 2);
    qy = perspective(p.y, 1'b1, gain, den, 4096, (ROWS - 1) / 2);
    if (!lines_on) begin
      push_plot(qx, qy, 1'b1);
    end else if (!p.first && prev_ok) begin
      dx = qx - prev_x;
      dy = qy - prev_y;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      mx = (ax > ay) ? ax : ay;
      n = (mx + UNIT - 1) >>> FRAC;
      if (n > 63) n = 63;
      push_plot(prev_x, prev_y, n == 0);
      for (int k = 1; k <= n; k++)
        push_plot(prev_x + step_offset(dx, k, n), prev_y + step_offset(dy, k, n), k == n);
    end
    prev_x = qx;
    prev_y = qy;
    prev_ok = 1'b1;
  endfunction

  // Input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        predict_plots(cur);
        points_in++;
      end
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          cur = pending_points.pop_front();
          pt_x <= cur.x;
          pt_y <= cur.y;
          pt_z <= cur.z;
          pt_first <= cur.first;
          in_valid <= 1'b1;
          gap_left = rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk_i) begin
    plot_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        plots_out++;
        if (expected_plots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected plot x=%0d y=%0d", plot_x_o, plot_y_o);
        end else begin
          e = expected_plots.pop_front();
          if (plot_x_o !== e.px || plot_y_o !== e.py || on_canvas_o !== e.on ||
              last_of_run_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("plot mismatch: exp x=%0d y=%0d on=%0b last=%0b, got x=%0d y=%0d on=%0b last=%0b",
                       e.px, e.py, e.on, e.last, plot_x_o, plot_y_o, on_canvas_o, last_of_run_o);
          end
        end
      end
      out_stall <= (rand_gap() > 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void add_point(int x, int y, int z, bit first);
    point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    p.first = first;
    pending_points.push_back(p);
  endfunction

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed($urandom_range(0, 8191)) - 4096;
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random objects: mostly polylines starting with first_point, some noise
  function automatic void add_objects(int count);
    int made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 4) == 0) begin
        add_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(0, 1));
        made++;
      end else begin
        add_point(rand_coord(), rand_coord(), rand_coord(), 1'b1);
        made++;
        repeat ($urandom_range(1, 5)) begin
          add_point(rand_coord(), rand_coord(), rand_coord(), 1'b0);
          made++;
        end
      end
    end
  endfunction

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_plots.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val[15:0];
    case (idx)
      CFG_DEPTH_RANGE: depth_reg  = val & 32'h7FFF;
      CFG_MIN_SCALE:   scale_reg  = val & 32'hFFFF;
      CFG_ASPECT:      aspect_reg = val & 32'h7FFF;
      CFG_LINE_MODE:   lines_on   = val[0];
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int unsigned dr, int unsigned ms, int unsigned asp, bit lm);
    write_reg(CFG_DEPTH_RANGE, dr);
    write_reg(CFG_MIN_SCALE, ms);
    write_reg(CFG_ASPECT, asp);
    write_reg(CFG_LINE_MODE, lm);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: line before any previous point, extremes, clamped depth, long lines
    add_point(0, 0, 0, 1'b0);
    add_point(0, 0, 0, 1'b0);
    add_point(32767, 32767, 32767, 1'b0);
    add_point(-32768, -32768, -32768, 1'b0);
    add_point(-32768, 32767, 0, 1'b0);
    add_point(1024, -1024, -4096, 1'b1);
    add_point(-1024, 1024, 4096, 1'b0);
    add_point(-1024, 1024, 4096, 1'b0);
    add_point(3840, 3840, 4096, 1'b0);
    add_point(-3840, -3840, -32768, 1'b0);
    add_point(256, 256, 32767, 1'b0);
    add_point(0, 0, -1, 1'b1);
    add_point(1, -1, -256, 1'b0);
    wait_drained();

    // Widest registers, no idling at all
    no_idle = 1'b1;
    set_regs(32767, 65535, 32767, 1'b1);
    add_point(0, 0, 0, 1'b1);
    add_point(32767, -32768, 32767, 1'b0);
    add_points_fixed: add_objects(25);
    wait_drained();
    no_idle = 1'b0;

    // Zero registers act as one, point mode
    set_regs(0, 0, 1, 1'b0);
    add_point(32767, -32768, 5, 1'b0);
    add_point(-32768, 32767, -5, 1'b1);
    add_objects(20);
    wait_drained();

    // Smallest nonzero depth range and minimum scale
    set_regs(1, 1, 4096, 1'b1);
    add_objects(25);
    wait_drained();

    // Random settings, then the reset values
    set_regs($urandom_range(1, 32767), $urandom_range(1, 65535), $urandom_range(1, 32767),
             1'b1);
    add_objects(30);
    wait_drained();
    set_regs($urandom_range(256, 8192), $urandom_range(1, 65535), $urandom_range(2048, 16384),
             1'b0);
    add_objects(20);
    wait_drained();
    set_regs(4096, 32768, 8192, 1'b1);
    add_objects(25);
    wait_drained();

    $display("covered %0d points and %0d plots over seven register settings,", points_in,
             plots_out);
    $display("both modes, zero and extreme registers, clamped depth and long lines");
    if (mismatches == 0 && expected_plots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
